@@ design/urx_pkg.sv @@
package urx_pkg;

    // item kinds carried in tuser
    localparam logic [1:0] FUNC_LINE  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    // register map
    localparam logic [3:0] REG_DATA  = 4'd0;
    localparam logic [3:0] REG_ISR   = 4'd1;
    localparam logic [3:0] REG_LCR   = 4'd2;
    localparam logic [3:0] REG_IFR   = 4'd3;
    localparam logic [3:0] REG_RFOR  = 4'd4;
    localparam logic [3:0] REG_TFOR  = 4'd5;
    localparam logic [3:0] REG_DLL   = 4'd6;
    localparam logic [3:0] REG_DLM   = 4'd7;
    localparam logic [3:0] REG_MRR   = 4'd8;
    localparam logic [3:0] REG_RFTLR = 4'd9;
    localparam logic [3:0] REG_CFR   = 4'd10;

    // interrupt bit positions in enable and flag registers
    localparam int RX_INT_BIT = 0;
    localparam int TX_INT_BIT = 1;

    // read value of the transmit fill level register
    localparam logic [7:0] TFOR_VALUE = 8'h00;

    // fifo commands from the register logic
    typedef struct packed {
        logic push;
        logic pop;
    } fifo_cmd_t;

endpackage

@@ design/uart_rx_fifo_register_block.sv @@
// uart register block with receive fifo and fill-level interrupt
// every access settles in one pass of register logic between the input and result registers
// throughput: one word per cycle while m_axis_tready takes each result
// reset: synchronous active-low aresetn clears fifo pointers, level, valid flags, reg file
// fifo storage itself is not reset; only written entries are ever popped
module uart_rx_fifo_register_block #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // reg_index[3:0], wr_data[11:4], line_byte[19:12], zero
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // read_data[7:0], tx_valid[8], tx_byte[16:9],
                                       // irq_pulse[17], rx_dropped[18], zero
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    // input stage
    logic       in_valid_reg, in_valid_next;
    logic [1:0] in_func_reg;
    logic [3:0] in_index_reg;
    logic [7:0] in_wdata_reg;
    logic [7:0] in_lbyte_reg;

    // register file
    logic [7:0] ie_reg, ie_next;
    logic [7:0] if_reg, if_next;
    logic [7:0] lcr_reg, lcr_next;
    logic [7:0] thr_reg, thr_next;
    logic [7:0] dll_reg, dll_next;
    logic [7:0] dlm_reg, dlm_next;

    // result stage
    logic       out_valid_reg, out_valid_next;
    logic [7:0] rdata_reg, rdata_next;
    logic       txv_reg, txv_next;
    logic [7:0] txb_reg, txb_next;
    logic       irq_reg, irq_next;
    logic       drop_reg, drop_next;

    logic               advance;
    logic               s_accept;
    logic               fifo_full;
    logic [CNT_W-1:0]   fill_count;
    logic [CNT_W-1:0]   fill_after;
    logic [7:0]         head_data;
    urx_pkg::fifo_cmd_t fifo_cmd;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_func_reg  <= s_axis_tuser[1:0];
            in_index_reg <= s_axis_tdata[3:0];
            in_wdata_reg <= s_axis_tdata[11:4];
            in_lbyte_reg <= s_axis_tdata[19:12];
        end
    end

    // receive fifo
    urx_rx_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rx_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (fifo_cmd),
        .push_data  (in_lbyte_reg),
        .fill_count (fill_count),
        .head_data  (head_data)
    );

    assign fifo_full    = (fill_count == CNT_W'(FIFO_DEPTH));
    assign fifo_cmd.push = advance && (in_func_reg == urx_pkg::FUNC_LINE) && !fifo_full;
    assign fifo_cmd.pop  = advance && (in_func_reg == urx_pkg::FUNC_READ)
                           && (in_index_reg == urx_pkg::REG_DATA) && (fill_count != '0);
    assign fill_after    = fill_count + CNT_W'(fifo_cmd.push);

    // access decode and register update
    always_comb begin
        ie_next    = ie_reg;
        if_next    = if_reg;
        lcr_next   = lcr_reg;
        thr_next   = thr_reg;
        dll_next   = dll_reg;
        dlm_next   = dlm_reg;
        rdata_next = 8'h00;
        txv_next   = 1'b0;
        txb_next   = 8'h00;
        irq_next   = 1'b0;
        drop_next  = 1'b0;

        if (advance) begin
            unique case (in_func_reg)
                urx_pkg::FUNC_LINE: begin
                    drop_next = fifo_full;
                    if ((CMP_W'(fill_after) >= CMP_W'(thr_reg))
                        && ie_reg[urx_pkg::RX_INT_BIT]) begin
                        if_next[urx_pkg::RX_INT_BIT] = 1'b1;
                        irq_next = 1'b1;
                    end
                end
                urx_pkg::FUNC_READ: begin
                    unique case (in_index_reg)
                        urx_pkg::REG_DATA: begin
                            rdata_next = (fill_count != '0) ? head_data : 8'h00;
                        end
                        urx_pkg::REG_ISR:  rdata_next = ie_reg;
                        urx_pkg::REG_LCR:  rdata_next = lcr_reg;
                        urx_pkg::REG_IFR: begin
                            rdata_next = if_reg;
                            if_next    = 8'h00;
                        end
                        urx_pkg::REG_RFOR: begin
                            rdata_next = (CMP_W'(fill_count) > CMP_W'(8'hFF)) ? 8'hFF
                                                                             : 8'(fill_count);
                        end
                        urx_pkg::REG_TFOR: rdata_next = urx_pkg::TFOR_VALUE;
                        urx_pkg::REG_DLL:  rdata_next = dll_reg;
                        urx_pkg::REG_DLM:  rdata_next = dlm_reg;
                        // mrr, rftlr, cfr and unused indexes read as zero
                        default: rdata_next = 8'h00;
                    endcase
                end
                urx_pkg::FUNC_WRITE: begin
                    unique case (in_index_reg)
                        urx_pkg::REG_DATA: begin
                            txv_next = 1'b1;
                            txb_next = in_wdata_reg;
                            if (ie_reg[urx_pkg::TX_INT_BIT]) begin
                                if_next[urx_pkg::TX_INT_BIT] = 1'b1;
                                irq_next = 1'b1;
                            end
                        end
                        urx_pkg::REG_ISR: begin
                            ie_next = in_wdata_reg;
                            if (in_wdata_reg[urx_pkg::TX_INT_BIT]) begin
                                if_next[urx_pkg::TX_INT_BIT] = 1'b1;
                                irq_next = 1'b1;
                            end
                        end
                        urx_pkg::REG_LCR:   lcr_next = in_wdata_reg;
                        urx_pkg::REG_DLL:   dll_next = in_wdata_reg;
                        urx_pkg::REG_DLM:   dlm_next = in_wdata_reg;
                        urx_pkg::REG_RFTLR: thr_next = in_wdata_reg;
                        // mrr and cfr have no readback; read-only and unused indexes ignored
                        default: ;
                    endcase
                end
                // unused kind: no effect, all-zero result
                default: ;
            endcase
        end
    end

    // result handshake
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ie_reg        <= 8'h00;
            if_reg        <= 8'h00;
            lcr_reg       <= 8'h00;
            thr_reg       <= 8'h00;
            dll_reg       <= 8'h00;
            dlm_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
        end else begin
            ie_reg        <= ie_next;
            if_reg        <= if_next;
            lcr_reg       <= lcr_next;
            thr_reg       <= thr_next;
            dll_reg       <= dll_next;
            dlm_reg       <= dlm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (advance) begin
            rdata_reg <= rdata_next;
            txv_reg   <= txv_next;
            txb_reg   <= txb_next;
            irq_reg   <= irq_next;
            drop_reg  <= drop_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, drop_reg, irq_reg, txb_reg, txv_reg, rdata_reg};

endmodule

@@ design/urx_rx_fifo.sv @@
module urx_rx_fifo #(
    parameter int FIFO_DEPTH = 16,
    localparam int PTR_W = $clog2(FIFO_DEPTH),
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  urx_pkg::fifo_cmd_t  cmd,
    input  logic [7:0]          push_data,
    output logic [CNT_W-1:0]    fill_count,
    output logic [7:0]          head_data
);

    logic [7:0]       mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       head_reg;

    // pointer and level update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (cmd.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd.pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (cmd.push && !cmd.pop) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.pop && !cmd.push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, with the head word read ahead and a bypass for a write to the head slot
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (cmd.push && (wr_ptr_reg == rd_ptr_next)) begin
            head_reg <= push_data;
        end else begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    assign fill_count = count_reg;
    assign head_data  = head_reg;

endmodule
